/* src/ttlc_pkg.sv */
// ----------------------------------------------------------------------------
// ttlc_pkg: shared types and codes of the ttl key cache
// Status and command codes, configuration register indexes, entry layout.
// ----------------------------------------------------------------------------
package ttlc_pkg;

  // widths fixed by the interface
  localparam int ADDR_W    = 32;
  localparam int IN_ADDRS  = 4;
  localparam int ACT_W     = 7;
  localparam int CNT_OUT_W = 3;

  // configuration reset values
  localparam logic [31:0]      TTL_RESET    = 32'd300000;
  localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

  // configuration register indexes
  localparam logic CFG_TTL    = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  // command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_MISS    = 3'd0,
    STAT_HIT     = 3'd1,
    STAT_UPDATED = 3'd2,
    STAT_FREE    = 3'd3,
    STAT_EVICTED = 3'd4,
    STAT_IGNORED = 3'd5
  } status_e;

  // one row of the entry memory
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] expiry;
    logic [31:0] access;
  } meta_t;

  localparam int META_W = $bits(meta_t);

endpackage

/* src/ttlc_ram.sv */
// ----------------------------------------------------------------------------
// ttlc_ram: simple dual-port synchronous ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ttlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* src/ttlc_scan.sv */
// ----------------------------------------------------------------------------
// ttlc_scan: scan sequencer of the ttl key cache
// Clears the entry memory after reset, then walks the active entries one per
// cycle for each command, doing read-modify-write on the table memories.
// ----------------------------------------------------------------------------
module ttlc_scan #(
  parameter int ENTRIES         = 64,
  parameter int ADDRS_PER_ENTRY = 4,
  localparam int IDX_W          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W          = IDX_W + 1,
  localparam int ROW_W          = ADDRS_PER_ENTRY * ttlc_pkg::ADDR_W
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic [31:0]                            ttl_i,
  input  logic [CNT_W-1:0]                       scan_len_i,
  // command
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic                                   cmd_i,
  input  logic [31:0]                            key_hash_i,
  input  logic [31:0]                            now_ms_i,
  input  ttlc_pkg::addr_t [ttlc_pkg::IN_ADDRS-1:0] ips_i,
  input  logic [2:0]                             in_count_i,
  // result
  output logic                                   done_o,
  output ttlc_pkg::status_e                      status_o,
  output ttlc_pkg::addr_t [ttlc_pkg::IN_ADDRS-1:0] out_ips_o,
  output logic [2:0]                             out_count_o,
  // memory ports
  output logic                                   re_o,
  output logic [IDX_W-1:0]                       raddr_o,
  input  ttlc_pkg::meta_t                        meta_rdata_i,
  input  logic [ROW_W-1:0]                       row_rdata_i,
  output logic [IDX_W-1:0]                       waddr_o,
  output logic                                   meta_we_o,
  output ttlc_pkg::meta_t                        meta_wdata_o,
  output logic                                   row_we_o,
  output logic [ROW_W-1:0]                       row_wdata_o
);

  import ttlc_pkg::*;

  localparam int LIMIT = (ADDRS_PER_ENTRY < IN_ADDRS) ? ADDRS_PER_ENTRY : IN_ADDRS;
  localparam int PAD_N = (ADDRS_PER_ENTRY > IN_ADDRS) ? ADDRS_PER_ENTRY : IN_ADDRS;
  localparam int PAD_W = PAD_N * ADDR_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    idx_q;
  logic                cmd_q;
  logic [31:0]         key_q;
  logic [31:0]         now_q;
  addr_t [IN_ADDRS-1:0] ips_q;
  logic [2:0]          cnt_q;
  logic                have_free_q;
  logic [IDX_W-1:0]    free_q;
  logic [IDX_W-1:0]    lru_q;
  logic [31:0]         lru_time_q;
  logic                done_q;
  status_e             status_q;
  addr_t [IN_ADDRS-1:0] out_ips_q;
  logic [2:0]          out_count_q;

  logic                 accept;
  logic                 is_last;
  logic                 key_hit;
  logic                 live;
  logic                 free_now;
  logic                 lru_now;
  logic [IDX_W-1:0]     target;
  meta_t                fill_meta;
  logic [ROW_W-1:0]     fill_row;
  addr_t [IN_ADDRS-1:0] hit_ips;
  logic [2:0]           hit_count;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // per-entry compares on the row just read
  assign is_last  = ((CNT_W'(idx_q) + 1'b1) == scan_len_i);
  assign key_hit  = (meta_rdata_i.key == key_q);
  assign live     = (meta_rdata_i.expiry > now_q);
  assign free_now = ((meta_rdata_i.key == '0) || !live) && !have_free_q;
  assign lru_now  = (meta_rdata_i.access < lru_time_q);
  assign target   = have_free_q ? free_q : lru_q;

  // new entry contents
  assign fill_meta = '{key: key_q, expiry: now_q + ttl_i, access: now_q};

  always_comb begin
    logic [PAD_W-1:0] ips_pad;
    ips_pad = PAD_W'(ips_q);
    fill_row = '0;
    for (int j = 0; j < ADDRS_PER_ENTRY; j++) begin
      if (4'(j) < {1'b0, cnt_q}) begin
        fill_row[j*ADDR_W +: ADDR_W] = ips_pad[j*ADDR_W +: ADDR_W];
      end
    end
  end

  // hit addresses, stopping at the first zero
  always_comb begin
    logic [PAD_W-1:0] row_pad;
    logic             run;
    row_pad   = PAD_W'(row_rdata_i);
    run       = 1'b1;
    hit_ips   = '0;
    hit_count = '0;
    for (int j = 0; j < IN_ADDRS; j++) begin
      if (j < LIMIT && run && (row_pad[j*ADDR_W +: ADDR_W] != '0)) begin
        hit_ips[j] = row_pad[j*ADDR_W +: ADDR_W];
        hit_count  = hit_count + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  // read one entry ahead of the one being evaluated
  always_comb begin
    re_o    = 1'b0;
    raddr_o = '0;
    if (accept) begin
      re_o = 1'b1;
    end else if (state_q == S_SCAN && !is_last) begin
      re_o    = 1'b1;
      raddr_o = idx_q + 1'b1;
    end
  end

  // write back to the table memories
  always_comb begin
    waddr_o      = idx_q;
    meta_we_o    = 1'b0;
    meta_wdata_o = '0;
    row_we_o     = 1'b0;
    row_wdata_o  = fill_row;
    case (state_q)
      S_CLEAR: begin
        meta_we_o = 1'b1;
      end
      S_SCAN: begin
        if (cmd_q == CMD_LOOKUP) begin
          if (key_hit && live) begin
            meta_we_o    = 1'b1;
            meta_wdata_o = '{key: meta_rdata_i.key, expiry: meta_rdata_i.expiry,
                             access: now_q};
          end
        end else if (key_hit) begin
          meta_we_o    = 1'b1;
          meta_wdata_o = fill_meta;
          row_we_o     = 1'b1;
        end else if (free_now) begin
          // release the first empty or expired entry
          meta_we_o    = 1'b1;
          meta_wdata_o = '{key: '0, expiry: meta_rdata_i.expiry,
                           access: meta_rdata_i.access};
        end
      end
      S_FILL: begin
        waddr_o      = target;
        meta_we_o    = 1'b1;
        meta_wdata_o = fill_meta;
        row_we_o     = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      cmd_q       <= CMD_LOOKUP;
      key_q       <= '0;
      now_q       <= '0;
      ips_q       <= '0;
      cnt_q       <= '0;
      have_free_q <= 1'b0;
      free_q      <= '0;
      lru_q       <= '0;
      lru_time_q  <= '1;
      done_q      <= 1'b0;
      status_q    <= STAT_MISS;
      out_ips_q   <= '0;
      out_count_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (idx_q == IDX_W'(ENTRIES - 1)) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            cmd_q       <= cmd_i;
            key_q       <= (key_hash_i == '0) ? 32'd1 : key_hash_i;
            now_q       <= now_ms_i;
            ips_q       <= ips_i;
            cnt_q       <= (in_count_i > 3'(LIMIT)) ? 3'(LIMIT) : in_count_i;
            idx_q       <= '0;
            have_free_q <= 1'b0;
            free_q      <= '0;
            lru_q       <= '0;
            lru_time_q  <= '1;
            if (cmd_i == CMD_INSERT && in_count_i == '0) begin
              done_q      <= 1'b1;
              status_q    <= STAT_IGNORED;
              out_ips_q   <= '0;
              out_count_q <= '0;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cmd_q == CMD_LOOKUP) begin
            if (key_hit && live) begin
              done_q      <= 1'b1;
              status_q    <= STAT_HIT;
              out_ips_q   <= hit_ips;
              out_count_q <= hit_count;
              state_q     <= S_IDLE;
            end else if (is_last) begin
              done_q      <= 1'b1;
              status_q    <= STAT_MISS;
              out_ips_q   <= '0;
              out_count_q <= '0;
              state_q     <= S_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else if (key_hit) begin
            done_q      <= 1'b1;
            status_q    <= STAT_UPDATED;
            out_ips_q   <= '0;
            out_count_q <= '0;
            state_q     <= S_IDLE;
          end else begin
            if (free_now) begin
              have_free_q <= 1'b1;
              free_q      <= idx_q;
            end
            if (lru_now) begin
              lru_time_q <= meta_rdata_i.access;
              lru_q      <= idx_q;
            end
            if (is_last) begin
              state_q <= S_FILL;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_FILL: begin
          done_q      <= 1'b1;
          status_q    <= have_free_q ? STAT_FREE : STAT_EVICTED;
          out_ips_q   <= '0;
          out_count_q <= '0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_ips_o   = out_ips_q;
  assign out_count_o = out_count_q;

endmodule

/* src/ttl_lru_key_cache.sv */
// ----------------------------------------------------------------------------
// ttl_lru_key_cache: fully associative key cache with expiry and lru refill
// Top level: configuration registers, table memories and scan sequencer.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. Each command
// walks the table from entry 0, one entry per cycle through the registered
// read port of the entry memory, so its cost is set by the number of entries
// examined (up to active_entries, clamped to 1 and ENTRIES); an insert placed
// in a free or least recently used entry has a fill step after the scan, and
// an insert with a count of zero answers on the next cycle. The result is on
// the output ports for the single cycle in which done_o is high and cannot be
// held off, so it must be captured then. After reset a clearing pass over
// all ENTRIES entries runs with busy_o high; configuration writes are taken
// at any time.
// ----------------------------------------------------------------------------
module ttl_lru_key_cache #(
  parameter int ENTRIES         = 64,
  parameter int ADDRS_PER_ENTRY = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // command
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [31:0] key_hash_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] in_ip0_i,
  input  logic [31:0] in_ip1_i,
  input  logic [31:0] in_ip2_i,
  input  logic [31:0] in_ip3_i,
  input  logic [2:0]  in_count_i,
  // result
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] out_ip0_o,
  output logic [31:0] out_ip1_o,
  output logic [31:0] out_ip2_o,
  output logic [31:0] out_ip3_o,
  output logic [2:0]  out_count_o
);

  import ttlc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;
  localparam int ROW_W = ADDRS_PER_ENTRY * ADDR_W;

  logic [31:0]          ttl_q;
  logic [ACT_W-1:0]     active_q;
  logic [CMP_W-1:0]     active_ext;
  logic [CNT_W-1:0]     scan_len;
  addr_t [IN_ADDRS-1:0] ips;
  addr_t [IN_ADDRS-1:0] out_ips;
  status_e              status;

  logic                 re;
  logic [IDX_W-1:0]     raddr;
  logic [IDX_W-1:0]     waddr;
  meta_t                meta_rdata;
  meta_t                meta_wdata;
  logic                 meta_we;
  logic [ROW_W-1:0]     row_rdata;
  logic [ROW_W-1:0]     row_wdata;
  logic                 row_we;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q    <= TTL_RESET;
      active_q <= ACTIVE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TTL:    ttl_q    <= cfg_wdata_i;
        CFG_ACTIVE: active_q <= cfg_wdata_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the scan length to 1 .. ENTRIES
  assign active_ext = CMP_W'(active_q);
  always_comb begin
    if (active_ext == '0) begin
      scan_len = CNT_W'(1);
    end else if (active_ext > CMP_W'(ENTRIES)) begin
      scan_len = CNT_W'(ENTRIES);
    end else begin
      scan_len = active_ext[CNT_W-1:0];
    end
  end

  assign ips = {in_ip3_i, in_ip2_i, in_ip1_i, in_ip0_i};

  // key, expiry and access time per entry
  ttlc_ram #(
    .WIDTH (META_W),
    .DEPTH (ENTRIES)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (waddr),
    .wdata_i (meta_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (meta_rdata)
  );

  // address row per entry
  ttlc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (waddr),
    .wdata_i (row_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (row_rdata)
  );

  ttlc_scan #(
    .ENTRIES         (ENTRIES),
    .ADDRS_PER_ENTRY (ADDRS_PER_ENTRY)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ttl_i        (ttl_q),
    .scan_len_i   (scan_len),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .key_hash_i   (key_hash_i),
    .now_ms_i     (now_ms_i),
    .ips_i        (ips),
    .in_count_i   (in_count_i),
    .done_o       (done_o),
    .status_o     (status),
    .out_ips_o    (out_ips),
    .out_count_o  (out_count_o),
    .re_o         (re),
    .raddr_o      (raddr),
    .meta_rdata_i (meta_rdata),
    .row_rdata_i  (row_rdata),
    .waddr_o      (waddr),
    .meta_we_o    (meta_we),
    .meta_wdata_o (meta_wdata),
    .row_we_o     (row_we),
    .row_wdata_o  (row_wdata)
  );

  assign status_o  = status;
  assign out_ip0_o = out_ips[0];
  assign out_ip1_o = out_ips[1];
  assign out_ip2_o = out_ips[2];
  assign out_ip3_o = out_ips[3];

endmodule

/* src/ttlc_checker.sv */
// ----------------------------------------------------------------------------
// ttlc_checker: port-level checks of the ttl key cache
// Watches commands and result transfers at the top level ports.
// ----------------------------------------------------------------------------
module ttlc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        cmd_i,
  input logic [2:0]  in_count_i,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [31:0] out_ip0_o,
  input logic [31:0] out_ip1_o,
  input logic [31:0] out_ip2_o,
  input logic [31:0] out_ip3_o,
  input logic [2:0]  out_count_o
);

  import ttlc_pkg::*;

  // an insert with no addresses answers as ignored on the next cycle
  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i == CMD_INSERT && in_count_i == 3'd0
      |=> done_o && status_o == STAT_IGNORED)
    else $error("empty insert not answered as ignored");

  // any other accepted command keeps the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !(cmd_i == CMD_INSERT && in_count_i == 3'd0) |=> busy_o)
    else $error("accepted command did not raise busy");

  // only a hit transfer carries addresses
  a_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STAT_HIT
      |-> out_count_o == 3'd0 && out_ip0_o == '0 && out_ip1_o == '0
          && out_ip2_o == '0 && out_ip3_o == '0)
    else $error("addresses on a non-hit transfer");

  // hit addresses stop at the first zero
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == STAT_HIT
      |-> out_count_o <= 3'd4 && (out_count_o != 3'd0 || out_ip0_o == '0)
          && (out_count_o == 3'd4 || out_ip3_o == '0))
    else $error("hit address count inconsistent");

  // a transfer carries a known status code and never finds the block busy
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o <= STAT_IGNORED && !busy_o)
    else $error("bad status or busy at result transfer");

endmodule

bind ttl_lru_key_cache ttlc_checker u_ttlc_checker (.*);

/* bench/tb_ttl_lru_key_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ttl_lru_key_cache: self-checking bench for the ttl key cache
// Sends lookup and insert transfers through the start/busy handshake. A
// behavioral copy of the table predicts every reply, and each done_o strobe
// is checked against the oldest prediction. The run goes through several
// lifetime and table-size settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_ttl_lru_key_cache;
  import ttlc_pkg::*;

  localparam int ENTRIES         = 64;
  localparam int ADDRS_PER_ENTRY = 4;
  localparam int ADDR_LIMIT      = (ADDRS_PER_ENTRY < IN_ADDRS) ? ADDRS_PER_ENTRY : IN_ADDRS;
  localparam int SETTLE          = 80;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_REPORTS     = 60;
  localparam int POOL_MAX        = 96;

  // one command as it goes over the handshake
  typedef struct packed {
    logic                       cmd;
    addr_t                      key;
    addr_t                      now;
    addr_t [IN_ADDRS-1:0]       ip;
    logic [2:0]                 count;
    logic                       hold;
  } cache_cmd_t;

  // one reply as seen on the result ports
  typedef struct packed {
    status_e                    status;
    addr_t [IN_ADDRS-1:0]       ip;
    logic [CNT_OUT_W-1:0]       count;
  } cache_reply_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        start_i     = 1'b0;
  logic        busy_o;
  logic        cmd_i       = 1'b0;
  logic [31:0] key_hash_i  = '0;
  logic [31:0] now_ms_i    = '0;
  logic [31:0] in_ip0_i    = '0;
  logic [31:0] in_ip1_i    = '0;
  logic [31:0] in_ip2_i    = '0;
  logic [31:0] in_ip3_i    = '0;
  logic [2:0]  in_count_i  = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] out_ip0_o;
  logic [31:0] out_ip1_o;
  logic [31:0] out_ip2_o;
  logic [31:0] out_ip3_o;
  logic [2:0]  out_count_o;

  // commands not yet driven, replies not yet seen
  cache_cmd_t   cmd_q[$];
  cache_reply_t reply_q[$];

  int   queued_n   = 0;
  int   accepted_n = 0;
  logic drained_q  = 1'b1;
  int   idle_pct   = 18;
  int   errors     = 0;
  int   cycle_n    = 0;
  addr_t tick      = '0;

  // predicted table contents and settings
  addr_t            tag_tbl    [ENTRIES];
  addr_t            expiry_tbl [ENTRIES];
  addr_t            touch_tbl  [ENTRIES];
  addr_t            ip_tbl     [ENTRIES][ADDRS_PER_ENTRY];
  addr_t            lifetime_cfg = TTL_RESET;
  logic [ACT_W-1:0] span_cfg     = ACTIVE_RESET;

  ttl_lru_key_cache #(
    .ENTRIES         (ENTRIES),
    .ADDRS_PER_ENTRY (ADDRS_PER_ENTRY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .key_hash_i  (key_hash_i),
    .now_ms_i    (now_ms_i),
    .in_ip0_i    (in_ip0_i),
    .in_ip1_i    (in_ip1_i),
    .in_ip2_i    (in_ip2_i),
    .in_ip3_i    (in_ip3_i),
    .in_count_i  (in_count_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .out_ip0_o   (out_ip0_o),
    .out_ip1_o   (out_ip1_o),
    .out_ip2_o   (out_ip2_o),
    .out_ip3_o   (out_ip3_o),
    .out_count_o (out_count_o)
  );

  // clock and reset
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // empty table after reset
  initial begin
    for (int e = 0; e < ENTRIES; e++) begin
      tag_tbl[e]    = '0;
      expiry_tbl[e] = '0;
      touch_tbl[e]  = '0;
      for (int j = 0; j < ADDRS_PER_ENTRY; j++) ip_tbl[e][j] = '0;
    end
  end

  // write key, addresses, expiry and access time of one entry
  function automatic void store_entry(int e, addr_t key, addr_t now,
                                      addr_t [IN_ADDRS-1:0] ips, int n);
    int j;
    tag_tbl[e] = key;
    for (j = 0; j < ADDRS_PER_ENTRY; j++) begin
      if (j < n) ip_tbl[e][j] = ips[j];
      else ip_tbl[e][j] = '0;
    end
    expiry_tbl[e] = now + lifetime_cfg;
    touch_tbl[e]  = now;
  endfunction

  // reply of one command, updating the predicted table
  function automatic cache_reply_t compute_reply(cache_cmd_t c);
    cache_reply_t r;
    addr_t        key;
    addr_t        lru_time;
    int           span, n, hit_at, free_at, lru_at, i, j;
    bit           ended, placed;
    r.status = STAT_MISS;
    r.ip     = '0;
    r.count  = '0;
    key      = (c.key == '0) ? 32'd1 : c.key;
    span     = (span_cfg == '0) ? 1 : ((span_cfg > ENTRIES) ? ENTRIES : int'(span_cfg));
    if (c.cmd == CMD_LOOKUP) begin
      // first live entry with this key
      hit_at = -1;
      for (i = 0; i < span; i++) begin
        if (hit_at < 0 && tag_tbl[i] == key && expiry_tbl[i] > c.now) hit_at = i;
      end
      if (hit_at >= 0) begin
        r.status = STAT_HIT;
        ended    = 1'b0;
        for (j = 0; j < ADDR_LIMIT; j++) begin
          if (ip_tbl[hit_at][j] == '0) ended = 1'b1;
          if (!ended) begin
            r.ip[j] = ip_tbl[hit_at][j];
            r.count = r.count + 1'b1;
          end
        end
        touch_tbl[hit_at] = c.now;
      end
    end else if (c.count == '0) begin
      r.status = STAT_IGNORED;
    end else begin
      // scan: update on key match, else remember first free and the lru entry
      n        = (c.count > ADDR_LIMIT) ? ADDR_LIMIT : int'(c.count);
      free_at  = -1;
      lru_at   = 0;
      lru_time = '1;
      placed   = 1'b0;
      for (i = 0; i < span; i++) begin
        if (!placed) begin
          if (tag_tbl[i] == key) begin
            store_entry(i, key, c.now, c.ip, n);
            r.status = STAT_UPDATED;
            placed   = 1'b1;
          end else begin
            if (free_at < 0 && (tag_tbl[i] == '0 || expiry_tbl[i] <= c.now)) begin
              free_at    = i;
              tag_tbl[i] = '0;
              for (j = 0; j < ADDRS_PER_ENTRY; j++) ip_tbl[i][j] = '0;
            end
            if (touch_tbl[i] < lru_time) begin
              lru_time = touch_tbl[i];
              lru_at   = i;
            end
          end
        end
      end
      if (!placed) begin
        if (free_at >= 0) begin
          store_entry(free_at, key, c.now, c.ip, n);
          r.status = STAT_FREE;
        end else begin
          store_entry(lru_at, key, c.now, c.ip, n);
          r.status = STAT_EVICTED;
        end
      end
    end
    return r;
  endfunction

  // driver: present the next command once the previous transfer is done
  always @(posedge clk_i) begin : drive
    cache_cmd_t nxt;
    if (rst_ni && (!start_i || !busy_o)) begin
      if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
          (!cmd_q[0].hold || (!start_i && drained_q))) begin
        nxt        = cmd_q.pop_front();
        cmd_i      <= nxt.cmd;
        key_hash_i <= nxt.key;
        now_ms_i   <= nxt.now;
        in_ip0_i   <= nxt.ip[0];
        in_ip1_i   <= nxt.ip[1];
        in_ip2_i   <= nxt.ip[2];
        in_ip3_i   <= nxt.ip[3];
        in_count_i <= nxt.count;
        start_i    <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: predict on each accepted transfer, check each reply strobe
  always @(posedge clk_i) begin : watch
    cache_cmd_t   seen;
    cache_reply_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        seen.cmd   = cmd_i;
        seen.key   = key_hash_i;
        seen.now   = now_ms_i;
        seen.ip    = {in_ip3_i, in_ip2_i, in_ip1_i, in_ip0_i};
        seen.count = in_count_i;
        seen.hold  = 1'b0;
        reply_q.insert(reply_q.size(), compute_reply(seen));
        accepted_n <= accepted_n + 1;
      end
      if (done_o) begin
        if (reply_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: reply with none expected, actual status %0d count %0d",
                     $time, status_o, out_count_o);
        end else begin
          want = reply_q.pop_front();
          if (status_o !== want.status || out_ip0_o !== want.ip[0] ||
              out_ip1_o !== want.ip[1] || out_ip2_o !== want.ip[2] ||
              out_ip3_o !== want.ip[3] || out_count_o !== want.count) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: expected %0d %h %h %h %h %0d, actual %0d %h %h %h %h %0d",
                       $time,
                       want.status, want.ip[0], want.ip[1], want.ip[2], want.ip[3],
                       want.count, status_o, out_ip0_o, out_ip1_o, out_ip2_o, out_ip3_o,
                       out_count_o);
          end
        end
      end
      drained_q <= (reply_q.size() == 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic enqueue(cache_cmd_t c);
    cmd_q.insert(cmd_q.size(), c);
    queued_n++;
  endtask

  task automatic push_cmd(logic cmd, addr_t key, addr_t now, addr_t ip0, addr_t ip1,
                          addr_t ip2, addr_t ip3, logic [2:0] count, logic hold);
    cache_cmd_t c;
    c.cmd   = cmd;
    c.key   = key;
    c.now   = now;
    c.ip    = {ip3, ip2, ip1, ip0};
    c.count = count;
    c.hold  = hold;
    enqueue(c);
  endtask

  // register write, mirrored into the predicted settings
  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TTL) lifetime_cfg = value;
    else span_cfg = value[ACT_W-1:0];
  endtask

  // wait until every transfer is taken and every reply has come
  task automatic settle();
    do @(posedge clk_i); while (!(accepted_n == queued_n && drained_q));
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // hit, miss, update, key zero, truncation, zero address, expiry edges, wrap
  task automatic queue_directed();
    addr_t k;
    @(negedge clk_i);
    k = 32'h1234_5678;
    push_cmd(CMD_LOOKUP, k, 32'd100, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_INSERT, k, 32'd100, 32'h0A00_0001, 32'h0A00_0002, 32'h0A00_0003,
             32'h0A00_0004, 3'd4, 1'b0);
    push_cmd(CMD_LOOKUP, k, 32'd200, '0, '0, '0, '0, 3'd0, 1'b1);
    push_cmd(CMD_INSERT, k, 32'd300, 32'hC0A8_0001, 32'hC0A8_0002, 32'hDEAD_BEEF,
             32'hFEED_F00D, 3'd2, 1'b0);
    push_cmd(CMD_LOOKUP, k, 32'd400, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_INSERT, '0, 32'd500, 32'h0101_0101, '0, 32'h0303_0303, 32'h0404_0404,
             3'd3, 1'b0);
    push_cmd(CMD_LOOKUP, 32'd1, 32'd600, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_LOOKUP, '0, 32'd600, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_INSERT, 32'h5555_AAAA, 32'd700, 32'h1, 32'h2, 32'h3, 32'h4, 3'd0, 1'b0);
    push_cmd(CMD_INSERT, '1, 32'd800, '1, '1, '1, '1, 3'd7, 1'b0);
    push_cmd(CMD_LOOKUP, '1, 32'd900, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_INSERT, 32'd2, 32'd1000, 32'h1, 32'h2, 32'h3, 32'h4, 3'd5, 1'b0);
    push_cmd(CMD_INSERT, 32'd3, 32'd1000, 32'h5, 32'h6, 32'h7, 32'h8, 3'd6, 1'b0);
    push_cmd(CMD_LOOKUP, k, 32'd300299, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_LOOKUP, k, 32'd300300, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_LOOKUP, k, '1, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFF0, 32'h7F00_0001, '0, '0, '0,
             3'd1, 1'b0);
    push_cmd(CMD_LOOKUP, 32'h8000_0000, 32'hFFFF_FFF0, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_INSERT, k, '0, 32'h8000_0000, 32'h4000_0000, 32'h2000_0000,
             32'h1000_0000, 3'd4, 1'b0);
    push_cmd(CMD_LOOKUP, 32'h8000_0000, '0, '0, '0, '0, '0, 3'd0, 1'b0);
    push_cmd(CMD_LOOKUP, k, 32'd1, '1, '1, '1, '1, 3'd7, 1'b0);
    push_cmd(CMD_INSERT, '0, 32'd2, 32'hAAAA_5555, 32'h5555_AAAA, 32'h0F0F_F0F0,
             32'hF0F0_0F0F, 3'd4, 1'b0);
  endtask

  // mostly ordered traffic over a small key set, with some random noise
  task automatic queue_traffic(int n);
    addr_t      pool [POOL_MAX];
    addr_t      stride;
    cache_cmd_t c;
    int         span, pool_n, i, j, r;
    @(negedge clk_i);
    span   = (span_cfg == '0) ? 1 : ((span_cfg > ENTRIES) ? ENTRIES : int'(span_cfg));
    pool_n = span + span / 2 + 2;
    if (pool_n > POOL_MAX) pool_n = POOL_MAX;
    for (i = 0; i < pool_n; i++) pool[i] = $urandom();
    if ($urandom_range(0, 1) == 0) pool[0] = '0;
    if ($urandom_range(0, 1) == 0) pool[1] = 32'd1;
    stride = lifetime_cfg / (2 * span) + 1;
    if ($urandom_range(0, 3) == 0) tick = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        tick    = tick + $urandom_range(0, stride);
        c.cmd   = 1'($urandom_range(0, 1));
        c.key   = pool[$urandom_range(0, pool_n - 1)];
        c.now   = tick;
        for (j = 0; j < IN_ADDRS; j++)
          c.ip[j] = ($urandom_range(0, 7) == 0) ? '0 : addr_t'($urandom());
        r = $urandom_range(0, 15);
        if (r == 0) c.count = '0;
        else if (r < 3) c.count = 3'($urandom_range(5, 7));
        else c.count = 3'($urandom_range(1, 4));
      end else begin
        c.cmd   = 1'($urandom_range(0, 1));
        c.key   = $urandom();
        c.now   = $urandom();
        for (j = 0; j < IN_ADDRS; j++) c.ip[j] = $urandom();
        c.count = 3'($urandom_range(0, 7));
      end
      c.hold = ($urandom_range(0, 63) == 0);
      enqueue(c);
    end
  endtask

  // phases: directed, extreme settings, then random settings
  initial begin : stimulus
    logic [31:0] span_word;
    logic [31:0] ttl_word;
    int          k;
    repeat (6) @(posedge clk_i);
    queue_directed();
    settle();
    write_reg(CFG_TTL, '0);
    write_reg(CFG_ACTIVE, '0);
    queue_traffic(40);
    settle();
    write_reg(CFG_TTL, '1);
    write_reg(CFG_ACTIVE, 32'h7F);
    queue_traffic(60);
    for (k = 0; k < 10; k++) begin
      settle();
      case (k % 5)
        0:       span_word = $urandom_range(2, 6);
        1:       span_word = $urandom_range(7, 20);
        2:       span_word = 32'd64;
        3:       span_word = ($urandom() & 32'hFFFF_FF80) | 32'd3;
        default: span_word = $urandom_range(0, 127);
      endcase
      ttl_word = (k == 9) ? $urandom() : $urandom_range(16, 4000);
      if (k == 3) idle_pct = 62;
      if (k == 7) idle_pct = 0;
      write_reg(CFG_TTL, ttl_word);
      write_reg(CFG_ACTIVE, span_word);
      queue_traffic(115);
    end
    settle();
    if (errors == 0 && reply_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
